// ===== rtl/msud_pkg.sv =====
// Shared widths, depths and pipeline types for the signed/unsigned divider.
package msud_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int ITER_STAGES = DATA_WIDTH;
    localparam int PIPE_DEPTH  = ITER_STAGES + 2;

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef struct packed {
        word_t rem;
        word_t num;
        word_t den;
        logic  q_neg;
        logic  r_neg;
    } iter_t;

endpackage

// ===== rtl/msud_if.sv =====
// Valid/ready channel interfaces for divider requests and results.
interface msud_req_if
    import msud_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t dividend;
    word_t divisor;
    logic  signed_mode;

    modport source (output valid, output dividend, output divisor, output signed_mode,
                    input ready);
    modport sink (input valid, input dividend, input divisor, input signed_mode,
                  output ready);
endinterface

interface msud_rsp_if
    import msud_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t quotient;
    word_t remainder;

    modport source (output valid, output quotient, output remainder, input ready);
    modport sink (input valid, input quotient, input remainder, output ready);
endinterface

// ===== rtl/mips_signed_unsigned_divider.sv =====
// Pipelined 32-bit signed/unsigned divider following the MIPS DIV and DIVU rules.
// The divider takes one item per cycle, when no stalled result holds it back, through 34
// register stages. An accepted item passes through every stage in order before its
// quotient and remainder appear in the output register. One stage takes the
// operand magnitudes, 32 stages each run one restoring subtract step on a 33-bit
// adder and retire one quotient bit, and one stage restores the signs into the
// output register. Each stage holds its own valid bit, so a stalled result only
// stops the stages behind it and empty stages keep filling while it waits. Division
// by zero and the most-negative-by-minus-one case fall out of the same datapath.
module mips_signed_unsigned_divider
    import msud_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    msud_req_if.sink   req,
    msud_rsp_if.source rsp
);

    function automatic iter_t div_step(iter_t s);
        logic [DATA_WIDTH:0] trial;
        iter_t               o;
        trial = {s.rem, s.num[DATA_WIDTH-1]} - {1'b0, s.den};
        o = s;
        if (!trial[DATA_WIDTH])
        begin
            o.rem = trial[DATA_WIDTH-1:0];
            o.num = {s.num[DATA_WIDTH-2:0], 1'b1};
        end
        else
        begin
            o.rem = {s.rem[DATA_WIDTH-2:0], s.num[DATA_WIDTH-1]};
            o.num = {s.num[DATA_WIDTH-2:0], 1'b0};
        end
        return o;
    endfunction

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH-1:0] advance;
    logic [PIPE_DEPTH-1:0] feed;

    iter_t pre_reg;
    iter_t pre_next;
    iter_t it_reg [ITER_STAGES];
    word_t quo_reg;
    word_t rem_reg;
    word_t quo_next;
    word_t rem_next;

    // Stage s moves when it is empty or its item moves on.
    for (genvar s = 0; s < PIPE_DEPTH; s++)
    begin : g_adv
        if (s == PIPE_DEPTH - 1)
        begin : g_last
            assign advance[s] = !valid_reg[s] || rsp.ready;
        end
        else
        begin : g_mid
            assign advance[s] = !valid_reg[s] || advance[s+1];
        end
    end

    assign feed = {valid_reg[PIPE_DEPTH-2:0], req.valid};

    always_comb
    begin
        for (int s = 0; s < PIPE_DEPTH; s++)
        begin
            valid_next[s] = advance[s] ? feed[s] : valid_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        pre_next.rem   = '0;
        pre_next.num   = (req.signed_mode && req.dividend[DATA_WIDTH-1]) ?
                         (~req.dividend + word_t'(1)) : req.dividend;
        pre_next.den   = (req.signed_mode && req.divisor[DATA_WIDTH-1]) ?
                         (~req.divisor + word_t'(1)) : req.divisor;
        pre_next.q_neg = req.signed_mode &&
                         (req.dividend[DATA_WIDTH-1] ^ req.divisor[DATA_WIDTH-1]);
        pre_next.r_neg = req.signed_mode && req.dividend[DATA_WIDTH-1];
    end

    always_ff @(posedge clk)
    begin
        if (advance[0])
        begin
            pre_reg <= pre_next;
        end
    end

    for (genvar k = 0; k < ITER_STAGES; k++)
    begin : g_iter
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (advance[1])
                begin
                    it_reg[k] <= div_step(pre_reg);
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (advance[k+1])
                begin
                    it_reg[k] <= div_step(it_reg[k-1]);
                end
            end
        end
    end

    always_comb
    begin
        quo_next = it_reg[ITER_STAGES-1].q_neg ?
                   (~it_reg[ITER_STAGES-1].num + word_t'(1)) : it_reg[ITER_STAGES-1].num;
        rem_next = it_reg[ITER_STAGES-1].r_neg ?
                   (~it_reg[ITER_STAGES-1].rem + word_t'(1)) : it_reg[ITER_STAGES-1].rem;
    end

    always_ff @(posedge clk)
    begin
        if (advance[PIPE_DEPTH-1])
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign req.ready     = advance[0];
    assign rsp.valid     = valid_reg[PIPE_DEPTH-1];
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== rtl/msud_checker.sv =====
// Port-level checks on the divider's item flow, bound to the top level.
module msud_flow_checker
    import msud_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input logic  out_valid,
    input logic  out_ready,
    input word_t quotient,
    input word_t remainder
);

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc)
        begin
            inflight_next = inflight_reg + CNT_W'(1);
        end
        else if (!in_acc && out_acc)
        begin
            inflight_next = inflight_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(quotient) && $stable(remainder))
        else $error("Stalled result item changed or vanished.");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != '0)
        else $error("Result item shown with no item in flight.");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(PIPE_DEPTH))
        else $error("More items in flight than pipeline stages.");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == ((inflight_reg != CNT_W'(PIPE_DEPTH)) || out_ready))
        else $error("Input ready does not match pipeline occupancy.");

endmodule

bind mips_signed_unsigned_divider msud_flow_checker u_msud_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .quotient  (rsp.quotient),
    .remainder (rsp.remainder)
);
